// ===== design/fisheye_point_distortion_macros.svh =====
// Assertion macros used by the fisheye_point_distortion design file
`ifndef FISHEYE_POINT_DISTORTION_MACROS_SVH
`define FISHEYE_POINT_DISTORTION_MACROS_SVH

// Implication checked on every clock edge outside reset
`define FPD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define FPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/fpd_pkg.sv =====
// ----------------------------------------------------------------------------
// fpd_pkg
// Shared widths, reset values, register indexes, stage counts and the item type for the fisheye point block.
// ----------------------------------------------------------------------------
package fpd_pkg;
	localparam int CoordW   = 16;
	localparam int DeltaW   = 17;
	localparam int Dist2W   = 34;
	localparam int RadiusW  = 15;
	localparam int MagW     = 4;
	localparam int DistW    = 17;
	localparam int NumW     = 35;
	localparam int DenW     = 22;
	localparam int FactorW  = 21;
	localparam logic [RadiusW-1:0] RadiusReset = 15'd819;
	localparam logic [MagW-1:0]    MagReset    = 4'd3;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 15;
	localparam logic [CfgIdxW-1:0] RegRadius = 1'b0;
	localparam logic [CfgIdxW-1:0] RegMag    = 1'b1;
	localparam int SqrtStages = 17;
	localparam int DivStages  = 21;

	typedef struct packed {
		logic signed [CoordW-1:0]  fx;
		logic signed [CoordW-1:0]  fy;
		logic signed [CoordW-1:0]  px;
		logic signed [CoordW-1:0]  py;
		logic signed [DeltaW-1:0]  dx;
		logic signed [DeltaW-1:0]  dy;
		logic                      in_lens;
		logic [RadiusW-1:0]        r;
		logic [MagW-1:0]           m;
	} fpd_item_t;
endpackage

// ===== design/fpd_sqrt.sv =====
// ----------------------------------------------------------------------------
// fpd_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module fpd_sqrt import fpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [Dist2W-1:0]    radicand,
	input  fpd_item_t            in_item,
	output logic                 out_valid,
	output logic [DistW-1:0]     root,
	output fpd_item_t            out_item
);
	logic [SqrtStages:0]     vld_s1;
	logic [Dist2W-1:0]       rem_s1  [SqrtStages+1];
	logic [Dist2W-1:0]       val_s1  [SqrtStages+1];
	logic [DistW-1:0]        res_s1  [SqrtStages+1];
	fpd_item_t               item_s1 [SqrtStages+1];

	assign vld_s1[0]  = in_valid;
	assign rem_s1[0]  = '0;
	assign val_s1[0]  = radicand;
	assign res_s1[0]  = '0;
	assign item_s1[0] = in_item;

	// stage k takes two radicand bits into the partial remainder
	for (genvar k = 0; k < SqrtStages; k++) begin : g_stage
		logic [Dist2W-1:0] rem_sh;
		logic [Dist2W-1:0] trial;
		always_comb begin
			rem_sh = {rem_s1[k][Dist2W-3:0], val_s1[k][Dist2W-1 -: 2]};
			trial  = Dist2W'({res_s1[k][DistW-1:0], 2'b01});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[k+1] <= 1'b0;
			end else begin
				vld_s1[k+1] <= vld_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			val_s1[k+1]  <= {val_s1[k][Dist2W-3:0], 2'b00};
			item_s1[k+1] <= item_s1[k];
			if (rem_sh >= trial) begin
				rem_s1[k+1] <= rem_sh - trial;
				res_s1[k+1] <= {res_s1[k][DistW-2:0], 1'b1};
			end else begin
				rem_s1[k+1] <= rem_sh;
				res_s1[k+1] <= {res_s1[k][DistW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s1[SqrtStages];
	assign root      = res_s1[SqrtStages];
	assign out_item  = item_s1[SqrtStages];
endmodule

// ===== design/fpd_div.sv =====
// ----------------------------------------------------------------------------
// fpd_div
// Pipelined restoring divider for the lens factor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fpd_div import fpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [NumW-1:0]      num,
	input  logic [DenW-1:0]      den,
	input  fpd_item_t            in_item,
	output logic                 out_valid,
	output logic [FactorW-1:0]   quot,
	output fpd_item_t            out_item
);
	// quotient fits in FactorW bits: num < 2^(FactorW) * den since (m+1)r <= 16 r and den >= r
	localparam int RemW = DenW + 1;
	logic [DivStages:0]   vld_s1;
	logic [RemW-1:0]      rem_s1  [DivStages+1];
	logic [NumW-1:0]      num_s1  [DivStages+1];
	logic [DenW-1:0]      den_s1  [DivStages+1];
	logic [FactorW-1:0]   q_s1    [DivStages+1];
	fpd_item_t            item_s1 [DivStages+1];

	assign vld_s1[0]  = in_valid;
	// upper bits of num below den are preloaded; quotient <= 16<<16 < 2^21
	assign rem_s1[0]  = RemW'(num[NumW-1:FactorW]);
	assign num_s1[0]  = num;
	assign den_s1[0]  = den;
	assign q_s1[0]    = '0;
	assign item_s1[0] = in_item;

	for (genvar k = 0; k < DivStages; k++) begin : g_stage
		logic [RemW-1:0] rem_sh;
		always_comb begin
			rem_sh = {rem_s1[k][RemW-2:0], num_s1[k][FactorW-1-k]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1[k+1] <= 1'b0;
			end else begin
				vld_s1[k+1] <= vld_s1[k];
			end
		end
		always_ff @(posedge clk) begin
			num_s1[k+1]  <= num_s1[k];
			den_s1[k+1]  <= den_s1[k];
			item_s1[k+1] <= item_s1[k];
			if (rem_sh >= RemW'(den_s1[k])) begin
				rem_s1[k+1] <= rem_sh - RemW'(den_s1[k]);
				q_s1[k+1]   <= {q_s1[k][FactorW-2:0], 1'b1};
			end else begin
				rem_s1[k+1] <= rem_sh;
				q_s1[k+1]   <= {q_s1[k][FactorW-2:0], 1'b0};
			end
		end
	end

	assign out_valid = vld_s1[DivStages];
	assign quot      = q_s1[DivStages];
	assign out_item  = item_s1[DivStages];
endmodule

// ===== design/fisheye_point_distortion.sv =====
// ----------------------------------------------------------------------------
// fisheye_point_distortion
// Fisheye lens distortion of grid points about a focus, Q4.12 fixed point.
// ----------------------------------------------------------------------------
// Usage: drive point_x/y and focus_x/y with start high; any cycle with start
// high is a transfer (busy is always low, the pipeline never stalls).
// One result appears on out_x, out_y, inside_lens with done high for one cycle.
// The item passes 3 + 17 + 21 + 2 = 43 register stages, and one item may enter
// every cycle: throughput one point per clock. The square root (one bit per
// stage) and the factor division (one bit per stage) set depth.
// Configuration: write cfg_we with cfg_index 0 (lens_radius) or 1
// (magnification); writes should be made while the pipeline is empty.
// Register values are sampled at entry and travel with each item.
// Reset clears all valid bits and restores radius 819 and magnification 3.
// The receiver cannot stall; results must be taken when done is high.
// ----------------------------------------------------------------------------
`include "fisheye_point_distortion_macros.svh"
module fisheye_point_distortion import fpd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [CoordW-1:0]  point_x,
	input  logic signed [CoordW-1:0]  point_y,
	input  logic signed [CoordW-1:0]  focus_x,
	input  logic signed [CoordW-1:0]  focus_y,
	input  logic                      cfg_we,
	input  logic [CfgIdxW-1:0]        cfg_index,
	input  logic [CfgDataW-1:0]       cfg_data,
	output logic                      done,
	output logic signed [CoordW-1:0]  out_x,
	output logic signed [CoordW-1:0]  out_y,
	output logic                      inside_lens
);
	logic [RadiusW-1:0] radius_q;
	logic [MagW-1:0]    mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RadiusReset;
			mag_q    <= MagReset;
		end else if (cfg_we) begin
			case (cfg_index)
				RegRadius: radius_q <= cfg_data[RadiusW-1:0];
				RegMag:    mag_q    <= cfg_data[MagW-1:0];
				default:   ;
			endcase
		end
	end

	assign busy = 1'b0;

	// s1: deltas
	logic      vld_s1, vld_s2, vld_s3;
	fpd_item_t it_s1, it_s2, it_s3;
	logic [Dist2W-1:0] dxx_s2, dyy_s2, d2_s3;
	logic [2*RadiusW-1:0] rr_s2;
	logic signed [2*DeltaW-1:0] dxx_w, dyy_w;
	fpd_item_t it_s3_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		it_s1.fx      <= focus_x;
		it_s1.fy      <= focus_y;
		it_s1.px      <= point_x;
		it_s1.py      <= point_y;
		it_s1.dx      <= DeltaW'(point_x) - DeltaW'(focus_x);
		it_s1.dy      <= DeltaW'(point_y) - DeltaW'(focus_y);
		it_s1.in_lens <= 1'b0;
		it_s1.r       <= radius_q;
		it_s1.m       <= mag_q;
	end

	// full-width squares; the inside flag joins the item at s3
	always_comb begin
		dxx_w   = it_s1.dx * it_s1.dx;
		dyy_w   = it_s1.dy * it_s1.dy;
		it_s3_d = it_s2;
		it_s3_d.in_lens = (dxx_s2 + dyy_s2) < Dist2W'(rr_s2);
	end

	// s2: squares; s3: sum and inside test
	always_ff @(posedge clk) begin
		it_s2  <= it_s1;
		dxx_s2 <= $unsigned(dxx_w);
		dyy_s2 <= $unsigned(dyy_w);
		rr_s2  <= it_s1.r * it_s1.r;
		it_s3  <= it_s3_d;
		d2_s3  <= dxx_s2 + dyy_s2;
	end

	logic              sq_vld;
	logic [DistW-1:0]  sq_root;
	fpd_item_t         sq_item;

	fpd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.in_valid(vld_s3), .radicand(d2_s3), .in_item(it_s3),
		.out_valid(sq_vld), .root(sq_root), .out_item(sq_item)
	);

	// m*d and (m+1)*r are small products; root below r is < 2^15 when inside
	logic [NumW-1:0]  num;
	logic [DenW-1:0]  den;
	always_comb begin
		num = NumW'((NumW'(sq_item.m) + NumW'(1)) * NumW'(sq_item.r)) << 16;
		den = DenW'(DenW'(sq_item.m) * DenW'(sq_root)) + DenW'(sq_item.r);
		if (!sq_item.in_lens) begin
			num = '0;
			den = DenW'(1);
		end
	end

	logic               dv_vld;
	logic [FactorW-1:0] factor;
	fpd_item_t          dv_item;

	fpd_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(sq_vld), .num(num), .den(den), .in_item(sq_item),
		.out_valid(dv_vld), .quot(factor), .out_item(dv_item)
	);

	// m1: offset products; m2: round, add, saturate, or pass the point through outside the lens
	localparam int ProdW = DeltaW + FactorW + 1;
	logic signed [ProdW-1:0] px_m1, py_m1;
	logic                    vld_m1;
	fpd_item_t               it_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_m1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_m1 <= dv_vld;
			done   <= vld_m1;
		end
	end

	always_ff @(posedge clk) begin
		it_m1 <= dv_item;
		px_m1 <= ProdW'(dv_item.dx) * $signed({1'b0, factor});
		py_m1 <= ProdW'(dv_item.dy) * $signed({1'b0, factor});
	end

	function automatic logic signed [CoordW-1:0] sat16(input logic signed [ProdW-1:0] v);
		logic signed [ProdW-1:0] hi, lo;
		hi = ProdW'(32767);
		lo = -ProdW'(32768);
		if (v > hi) return CoordW'(32767);
		if (v < lo) return CoordW'(-32768);
		return v[CoordW-1:0];
	endfunction

	logic signed [ProdW-1:0] ox, oy;
	always_comb begin
		ox = ProdW'(it_m1.fx) + ((px_m1 + ProdW'(32768)) >>> 16);
		oy = ProdW'(it_m1.fy) + ((py_m1 + ProdW'(32768)) >>> 16);
	end

	always_ff @(posedge clk) begin
		if (it_m1.in_lens) begin
			out_x <= sat16(ox);
			out_y <= sat16(oy);
		end else begin
			out_x <= it_m1.px;
			out_y <= it_m1.py;
		end
		inside_lens <= it_m1.in_lens;
	end

	`FPD_ASSERT_IMP(a_never_busy, 1'b1, !busy, "busy raised")
	`FPD_ASSERT_NEXT(a_done_follows, vld_m1, done, "result lost at output")
	`FPD_ASSERT_IMP(a_zero_radius, vld_s3 && it_s3.r == '0, !it_s3.in_lens, "zero radius marked inside")
endmodule
